// ===== rtl/lfu_pkg.sv =====
package lfu_pkg;

    localparam int KEY_W = 32;
    localparam int VAL_W = 32;
    localparam int CAP_W = 5;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    localparam logic KIND_GET = 1'b0;
    localparam logic KIND_PUT = 1'b1;

endpackage

// ===== rtl/lfu_if.sv =====
interface lfu_req_if;
    logic                                valid;
    logic                                ready;
    logic                                kind;
    logic signed [lfu_pkg::KEY_W-1:0]    lookup_key;
    logic signed [lfu_pkg::VAL_W-1:0]    store_value;

    modport source (output valid, output kind, output lookup_key, output store_value,
                    input ready);
    modport sink   (input valid, input kind, input lookup_key, input store_value,
                    output ready);
endinterface

interface lfu_rsp_if;
    logic                                valid;
    logic                                ready;
    logic                                hit;
    logic signed [lfu_pkg::VAL_W-1:0]    read_value;

    modport source (output valid, output hit, output read_value, input ready);
    modport sink   (input valid, input hit, input read_value, output ready);
endinterface

interface lfu_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [lfu_pkg::CAP_W-1:0]           capacity_in_use;

    modport source (output valid, output capacity_in_use, input ready);
    modport sink   (input valid, input capacity_in_use, output ready);
endinterface

// ===== rtl/lfu_ram.sv =====
module lfu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                       clk,
    input  logic                                       we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/lfu_cache_lru_tiebreak.sv =====
// channel  dir  beat payload                       accepted when
// cfg      in   capacity_in_use                    cfg.valid && cfg.ready (ready always 1)
// req      in   kind, lookup_key, store_value      req.valid && req.ready
// rsp      out  hit, read_value                    rsp.valid && rsp.ready
//
// each request makes one pass over the entry and rank memories, one read a cycle,
// then a commit state; the single scan port sets how long a request takes
// a new request is taken in the commit state, so back-to-back requests need no idle
// state between them; req.ready is low during the scan
// the result sits in an output register; a stalled rsp holds the commit cycle
// reset clears valid bits, occupancy and the deferred rank update; no clearing pass
module lfu_cache_lru_tiebreak #(
    parameter int ENTRIES    = 16,
    parameter int COUNT_BITS = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    lfu_cfg_if.sink    cfg,
    lfu_req_if.sink    req,
    lfu_rsp_if.source  rsp
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int CMP_W = (CNT_W > lfu_pkg::CAP_W) ? CNT_W : lfu_pkg::CAP_W;
    localparam int ENT_W = lfu_pkg::KEY_W + lfu_pkg::VAL_W + COUNT_BITS;

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SCAN   = 3'b010,
        S_COMMIT = 3'b100
    } state_t;

    state_t state_reg, state_next;

    logic [lfu_pkg::CAP_W-1:0] cap_reg, cap_next;
    logic [ENTRIES-1:0]        valid_reg, valid_next;
    logic [CNT_W-1:0]          occ_reg, occ_next;
    logic [CNT_W-1:0]          scan_reg, scan_next;
    logic                      proc_vld_reg, proc_vld_next;
    logic [IDX_W-1:0]          proc_idx_reg, proc_idx_next;

    // current request
    logic                      kind_reg, kind_next;
    logic [lfu_pkg::KEY_W-1:0] key_reg, key_next;
    logic [lfu_pkg::VAL_W-1:0] sval_reg, sval_next;

    // scan trackers
    logic                      hit_reg, hit_next;
    logic [IDX_W-1:0]          hit_idx_reg, hit_idx_next;
    logic [lfu_pkg::VAL_W-1:0] hit_val_reg, hit_val_next;
    logic [COUNT_BITS-1:0]     hit_cnt_reg, hit_cnt_next;
    logic [IDX_W-1:0]          hit_rank_reg, hit_rank_next;
    logic                      vic_reg, vic_next;
    logic [IDX_W-1:0]          vic_idx_reg, vic_idx_next;
    logic [COUNT_BITS-1:0]     vic_cnt_reg, vic_cnt_next;
    logic [IDX_W-1:0]          vic_rank_reg, vic_rank_next;
    logic                      free_reg, free_next;
    logic [IDX_W-1:0]          free_idx_reg, free_idx_next;

    // rank update deferred to the next scan
    logic                      pend_reg, pend_next;
    logic                      pend_all_reg, pend_all_next;
    logic [IDX_W-1:0]          pend_slot_reg, pend_slot_next;
    logic [IDX_W-1:0]          pend_rank_reg, pend_rank_next;

    logic                      out_vld_reg, out_vld_next;
    logic                      out_hit_reg, out_hit_next;
    logic [lfu_pkg::VAL_W-1:0] out_val_reg, out_val_next;

    logic                      ent_we;
    logic [IDX_W-1:0]          ent_waddr;
    logic [ENT_W-1:0]          ent_wdata;
    logic [ENT_W-1:0]          ent_rdata;
    logic                      rank_we;
    logic [IDX_W-1:0]          rank_waddr;
    logic [IDX_W-1:0]          rank_wdata;
    logic [IDX_W-1:0]          rank_rdata;
    logic [IDX_W-1:0]          rd_addr;

    logic                      commit_go;
    logic                      accept;
    logic [CMP_W-1:0]          cap_eff;
    logic                      full;
    logic                      cur_valid;
    logic                      bump;
    logic [IDX_W-1:0]          rank_adj;
    logic [lfu_pkg::KEY_W-1:0] cur_key;
    logic [lfu_pkg::VAL_W-1:0] cur_val;
    logic [COUNT_BITS-1:0]     cur_cnt;

    logic                      do_wr;
    logic                      do_ins;
    logic [IDX_W-1:0]          wr_slot;
    logic [lfu_pkg::VAL_W-1:0] wr_val;
    logic [COUNT_BITS-1:0]     wr_cnt;
    logic [IDX_W-1:0]          wr_rank;
    logic                      wr_all;

    lfu_ram #(.WIDTH(ENT_W), .DEPTH(ENTRIES)) u_ent_ram (
        .clk   (clk),
        .we    (ent_we),
        .waddr (ent_waddr),
        .wdata (ent_wdata),
        .raddr (rd_addr),
        .rdata (ent_rdata)
    );

    lfu_ram #(.WIDTH(IDX_W), .DEPTH(ENTRIES)) u_rank_ram (
        .clk   (clk),
        .we    (rank_we),
        .waddr (rank_waddr),
        .wdata (rank_wdata),
        .raddr (rd_addr),
        .rdata (rank_rdata)
    );

    assign cfg.ready      = 1'b1;
    assign rsp.valid      = out_vld_reg;
    assign rsp.hit        = out_hit_reg;
    assign rsp.read_value = out_val_reg;

    assign commit_go = !out_vld_reg || rsp.ready;
    assign req.ready = (state_reg == S_IDLE) || ((state_reg == S_COMMIT) && commit_go);
    assign accept    = req.valid && req.ready;

    assign cap_eff = (CMP_W'(cap_reg) < CMP_W'(ENTRIES)) ? CMP_W'(cap_reg) : CMP_W'(ENTRIES);
    assign full    = CMP_W'(occ_reg) >= cap_eff;

    assign rd_addr = scan_reg[IDX_W-1:0];

    assign cur_key   = ent_rdata[ENT_W-1 -: lfu_pkg::KEY_W];
    assign cur_val   = ent_rdata[COUNT_BITS +: lfu_pkg::VAL_W];
    assign cur_cnt   = ent_rdata[COUNT_BITS-1:0];
    assign cur_valid = valid_reg[proc_idx_reg];

    // stored rank lags by one update; fix it up on the way past
    assign bump = pend_reg && cur_valid && (proc_idx_reg != pend_slot_reg)
                  && (pend_all_reg || (rank_rdata < pend_rank_reg));
    assign rank_adj = bump ? rank_rdata + IDX_W'(1) : rank_rdata;

    // commit decision
    always_comb
    begin
        do_wr   = 1'b0;
        do_ins  = 1'b0;
        wr_slot = hit_idx_reg;
        wr_val  = sval_reg;
        wr_cnt  = (hit_cnt_reg == {COUNT_BITS{1'b1}}) ? hit_cnt_reg
                                                       : hit_cnt_reg + COUNT_BITS'(1);
        wr_rank = hit_rank_reg;
        wr_all  = 1'b0;
        if (kind_reg == lfu_pkg::KIND_GET)
        begin
            if (hit_reg)
            begin
                do_wr  = 1'b1;
                wr_val = hit_val_reg;
            end
        end
        else if (cap_reg != '0)
        begin
            if (hit_reg)
            begin
                do_wr = 1'b1;
            end
            else if (full && vic_reg)
            begin
                // evict then insert ages only what was newer than the victim
                do_wr   = 1'b1;
                wr_slot = vic_idx_reg;
                wr_cnt  = COUNT_BITS'(1);
                wr_rank = vic_rank_reg;
            end
            else if (!full && free_reg)
            begin
                do_wr   = 1'b1;
                do_ins  = 1'b1;
                wr_slot = free_idx_reg;
                wr_cnt  = COUNT_BITS'(1);
                wr_all  = 1'b1;
            end
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cap_next       = cap_reg;
        valid_next     = valid_reg;
        occ_next       = occ_reg;
        scan_next      = scan_reg;
        proc_vld_next  = proc_vld_reg;
        proc_idx_next  = proc_idx_reg;
        kind_next      = kind_reg;
        key_next       = key_reg;
        sval_next      = sval_reg;
        hit_next       = hit_reg;
        hit_idx_next   = hit_idx_reg;
        hit_val_next   = hit_val_reg;
        hit_cnt_next   = hit_cnt_reg;
        hit_rank_next  = hit_rank_reg;
        vic_next       = vic_reg;
        vic_idx_next   = vic_idx_reg;
        vic_cnt_next   = vic_cnt_reg;
        vic_rank_next  = vic_rank_reg;
        free_next      = free_reg;
        free_idx_next  = free_idx_reg;
        pend_next      = pend_reg;
        pend_all_next  = pend_all_reg;
        pend_slot_next = pend_slot_reg;
        pend_rank_next = pend_rank_reg;
        out_vld_next   = out_vld_reg;
        out_hit_next   = out_hit_reg;
        out_val_next   = out_val_reg;
        ent_we         = 1'b0;
        ent_waddr      = wr_slot;
        ent_wdata      = {key_reg, wr_val, wr_cnt};
        rank_we        = 1'b0;
        rank_waddr     = proc_idx_reg;
        rank_wdata     = rank_adj;

        if (cfg.valid)
        begin
            cap_next = cfg.capacity_in_use;
        end

        if (out_vld_reg && rsp.ready)
        begin
            out_vld_next = 1'b0;
        end

        // one entry leaves the read register each cycle
        if (proc_vld_reg)
        begin
            rank_we = bump;
            if (cur_valid)
            begin
                if (cur_key == key_reg)
                begin
                    hit_next      = 1'b1;
                    hit_idx_next  = proc_idx_reg;
                    hit_val_next  = cur_val;
                    hit_cnt_next  = cur_cnt;
                    hit_rank_next = rank_adj;
                end
                if (!vic_reg || (cur_cnt < vic_cnt_reg)
                    || ((cur_cnt == vic_cnt_reg) && (rank_adj > vic_rank_reg)))
                begin
                    vic_next      = 1'b1;
                    vic_idx_next  = proc_idx_reg;
                    vic_cnt_next  = cur_cnt;
                    vic_rank_next = rank_adj;
                end
            end
            else if (!free_reg)
            begin
                free_next     = 1'b1;
                free_idx_next = proc_idx_reg;
            end
        end

        case (state_reg)
            S_IDLE:
            begin
                proc_vld_next = 1'b0;
            end
            S_SCAN:
            begin
                if (scan_reg < CNT_W'(ENTRIES))
                begin
                    proc_vld_next = 1'b1;
                    proc_idx_next = scan_reg[IDX_W-1:0];
                    scan_next     = scan_reg + CNT_W'(1);
                end
                else
                begin
                    proc_vld_next = 1'b0;
                    state_next    = S_COMMIT;
                end
            end
            S_COMMIT:
            begin
                if (commit_go)
                begin
                    state_next     = S_IDLE;
                    out_vld_next   = 1'b1;
                    out_hit_next   = hit_reg &&
                                     ((kind_reg == lfu_pkg::KIND_GET) || (cap_reg != '0));
                    out_val_next   = ((kind_reg == lfu_pkg::KIND_GET) && hit_reg)
                                     ? hit_val_reg : '0;
                    pend_next      = do_wr;
                    pend_all_next  = wr_all;
                    pend_slot_next = wr_slot;
                    pend_rank_next = wr_rank;
                    if (do_wr)
                    begin
                        ent_we     = 1'b1;
                        rank_we    = 1'b1;
                        rank_waddr = wr_slot;
                        rank_wdata = '0;
                    end
                    if (do_ins)
                    begin
                        valid_next[wr_slot] = 1'b1;
                        occ_next            = occ_reg + CNT_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (accept)
        begin
            state_next = S_SCAN;
            scan_next  = '0;
            kind_next  = req.kind;
            key_next   = req.lookup_key;
            sval_next  = req.store_value;
            hit_next   = 1'b0;
            vic_next   = 1'b0;
            free_next  = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            cap_reg      <= lfu_pkg::CAP_RESET;
            valid_reg    <= '0;
            occ_reg      <= '0;
            scan_reg     <= '0;
            proc_vld_reg <= 1'b0;
            pend_reg     <= 1'b0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cap_reg      <= cap_next;
            valid_reg    <= valid_next;
            occ_reg      <= occ_next;
            scan_reg     <= scan_next;
            proc_vld_reg <= proc_vld_next;
            pend_reg     <= pend_next;
            out_vld_reg  <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        proc_idx_reg  <= proc_idx_next;
        kind_reg      <= kind_next;
        key_reg       <= key_next;
        sval_reg      <= sval_next;
        hit_reg       <= hit_next;
        hit_idx_reg   <= hit_idx_next;
        hit_val_reg   <= hit_val_next;
        hit_cnt_reg   <= hit_cnt_next;
        hit_rank_reg  <= hit_rank_next;
        vic_reg       <= vic_next;
        vic_idx_reg   <= vic_idx_next;
        vic_cnt_reg   <= vic_cnt_next;
        vic_rank_reg  <= vic_rank_next;
        free_reg      <= free_next;
        free_idx_reg  <= free_idx_next;
        pend_all_reg  <= pend_all_next;
        pend_slot_reg <= pend_slot_next;
        pend_rank_reg <= pend_rank_next;
        out_hit_reg   <= out_hit_next;
        out_val_reg   <= out_val_next;
    end

`ifndef SYNTH
    a_occ_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg == CNT_W'($countones(valid_reg)))
        else $error("occupancy differs from valid entries");

    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= CNT_W'(ENTRIES))
        else $error("occupancy above entry count");

    a_no_accept_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> !req.ready)
        else $error("request taken during scan");

    a_miss_reads_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && !rsp.hit) |-> (rsp.read_value == '0))
        else $error("miss returns nonzero value");

    a_pend_slot_valid: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> valid_reg[pend_slot_reg])
        else $error("deferred rank update names an empty slot");
`endif

endmodule

// ===== tb/sv/lfu_cache_lru_tiebreak_test.sv =====
module lfu_cache_lru_tiebreak_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS       = 16;
    localparam int COUNT_W     = 16;
    localparam int SCAN_CYCLES = SLOTS + 2;
    localparam int POOL_SIZE   = 24;

    typedef struct packed {
        logic                             kind;
        logic signed [lfu_pkg::KEY_W-1:0] key;
        logic signed [lfu_pkg::VAL_W-1:0] value;
    } cache_op_t;

    typedef struct packed {
        logic                             hit;
        logic signed [lfu_pkg::VAL_W-1:0] read_value;
    } cache_reply_t;

    logic clk;
    logic rst_n;

    lfu_cfg_if cfg_ch ();
    lfu_req_if req_ch ();
    lfu_rsp_if rsp_ch ();

    lfu_cache_lru_tiebreak #(
        .ENTRIES    (SLOTS),
        .COUNT_BITS (COUNT_W)
    ) uut (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_ch),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // shadow copy of the cache contents
    logic                      line_valid [SLOTS];
    logic [lfu_pkg::KEY_W-1:0] line_key   [SLOTS];
    logic [lfu_pkg::VAL_W-1:0] line_value [SLOTS];
    logic [COUNT_W-1:0]        line_uses  [SLOTS];
    logic [3:0]                line_age   [SLOTS];
    logic [lfu_pkg::CAP_W-1:0] lines_held;
    logic [lfu_pkg::CAP_W-1:0] capacity_setting;

    cache_reply_t reply_queue [$];

    logic signed [lfu_pkg::KEY_W-1:0] key_pool [POOL_SIZE];

    bit offering;
    bit req_idle_on;
    bit rsp_idle_on;
    int rsp_hold_cycles;
    int error_count;
    int gets_sent;
    int puts_sent;
    int hits_seen;
    int capacity_writes;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #60ms;
        $display("timeout with %0d replies outstanding", reply_queue.size());
        $display("status: fail");
        $finish;
    end

    function automatic void clear_shadow();
        for (int i = 0; i < SLOTS; i++)
        begin
            line_valid[i] = 1'b0;
        end
        lines_held       = '0;
        capacity_setting = lfu_pkg::CAP_RESET;
    endfunction

    // hit: bump the use count (saturating) and make the line most recent
    function automatic void promote_line(int s);
        logic [3:0] r;
        r = line_age[s];
        for (int i = 0; i < SLOTS; i++)
        begin
            if (line_valid[i] && line_age[i] < r)
                line_age[i]++;
        end
        line_age[s] = '0;
        if (line_uses[s] != '1)
            line_uses[s]++;
    endfunction

    // lowest use count wins, ties go to the least recently touched line
    function automatic int pick_victim();
        int v;
        v = -1;
        for (int i = 0; i < SLOTS; i++)
        begin
            if (!line_valid[i])
                continue;
            if (v < 0 || line_uses[i] < line_uses[v] ||
                (line_uses[i] == line_uses[v] && line_age[i] > line_age[v]))
                v = i;
        end
        return v;
    endfunction

    function automatic void drop_line(int v);
        logic [3:0] r;
        r = line_age[v];
        line_valid[v] = 1'b0;
        for (int i = 0; i < SLOTS; i++)
        begin
            if (line_valid[i] && line_age[i] > r)
                line_age[i]--;
        end
        if (lines_held > 0)
            lines_held--;
    endfunction

    function automatic cache_reply_t apply_cache_op(cache_op_t op);
        cache_reply_t rep;
        int           s;
        int           limit;
        rep   = '0;
        s     = -1;
        limit = (capacity_setting < SLOTS) ? int'(capacity_setting) : SLOTS;
        for (int i = 0; i < SLOTS; i++)
        begin
            if (s < 0 && line_valid[i] && line_key[i] == op.key)
                s = i;
        end
        if (op.kind == lfu_pkg::KIND_GET)
        begin
            if (s >= 0)
            begin
                rep.hit        = 1'b1;
                rep.read_value = line_value[s];
                promote_line(s);
            end
            return rep;
        end
        if (limit == 0)
            return rep;
        if (s >= 0)
        begin
            rep.hit       = 1'b1;
            line_value[s] = op.value;
            promote_line(s);
            return rep;
        end
        if (lines_held >= limit)
        begin
            s = pick_victim();
            if (s >= 0)
                drop_line(s);
        end
        if (s < 0)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                if (s < 0 && !line_valid[i])
                    s = i;
            end
        end
        if (s < 0)
            return rep;
        for (int i = 0; i < SLOTS; i++)
        begin
            if (line_valid[i])
                line_age[i]++;
        end
        line_valid[s] = 1'b1;
        line_key[s]   = op.key;
        line_value[s] = op.value;
        line_uses[s]  = COUNT_W'(1);
        line_age[s]   = '0;
        lines_held++;
        return rep;
    endfunction

    task automatic issue_op(input logic kind, input logic signed [lfu_pkg::KEY_W-1:0] key,
                            input logic signed [lfu_pkg::VAL_W-1:0] value);
        int        gap;
        cache_op_t op;
        gap = req_idle_on ? $urandom_range(0, 19) : 0;
        op  = {kind, key, value};
        if (gap > 0)
        begin
            if (offering)
            begin
                req_ch.valid <= 1'b0;
                offering = 1'b0;
            end
            repeat (gap) @(posedge clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.kind        <= kind;
        req_ch.lookup_key  <= key;
        req_ch.store_value <= value;
        offering = 1'b1;
        do
            @(posedge clk);
        while (!req_ch.ready);
        reply_queue.push_back(apply_cache_op(op));
        if (kind == lfu_pkg::KIND_GET)
            gets_sent++;
        else
            puts_sent++;
    endtask

    task automatic settle();
        if (offering)
        begin
            req_ch.valid <= 1'b0;
            offering = 1'b0;
        end
        while (reply_queue.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_capacity(input logic [lfu_pkg::CAP_W-1:0] cap);
        settle();
        cfg_ch.valid           <= 1'b1;
        cfg_ch.capacity_in_use <= cap;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        capacity_setting = cap;
        capacity_writes++;
        @(posedge clk);
    endtask

    task automatic random_op();
        logic                             kind;
        logic signed [lfu_pkg::KEY_W-1:0] key;
        kind = $urandom_range(0, 1) ? lfu_pkg::KIND_PUT : lfu_pkg::KIND_GET;
        if ($urandom_range(0, 99) < 85)
            key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
        else
            key = $urandom;
        issue_op(kind, key, $urandom);
    endtask

    always @(posedge clk)
    begin
        cache_reply_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (reply_queue.size() == 0)
            begin
                $error("reply beat with nothing outstanding: hit=%0b read_value=%0d",
                       rsp_ch.hit, rsp_ch.read_value);
                error_count++;
            end
            else
            begin
                want = reply_queue.pop_front();
                if (rsp_ch.hit !== want.hit)
                begin
                    $error("hit: expected %0b, got %0b", want.hit, rsp_ch.hit);
                    error_count++;
                end
                if (rsp_ch.read_value !== want.read_value)
                begin
                    $error("read_value: expected %0d, got %0d",
                           want.read_value, rsp_ch.read_value);
                    error_count++;
                end
                if (want.hit)
                    hits_seen++;
            end
        end
    end

    initial
    begin
        int stall;
        rsp_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (rsp_hold_cycles > 0)
            begin
                stall = rsp_hold_cycles;
                rsp_hold_cycles = 0;
            end
            else
            begin
                stall = rsp_idle_on ? $urandom_range(0, 19) : 0;
            end
            if (stall > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!rsp_ch.valid);
        end
    end

    task automatic test_lookup_and_store();
        issue_op(lfu_pkg::KIND_GET, 32'sd5, 32'sd0);
        issue_op(lfu_pkg::KIND_PUT, 32'h8000_0000, 32'h7fff_ffff);
        issue_op(lfu_pkg::KIND_PUT, 32'h7fff_ffff, 32'h8000_0000);
        issue_op(lfu_pkg::KIND_PUT, 32'sd0, -32'sd1);
        issue_op(lfu_pkg::KIND_PUT, -32'sd1, 32'sd0);
        issue_op(lfu_pkg::KIND_GET, 32'h8000_0000, 32'h1234_5678);
        issue_op(lfu_pkg::KIND_PUT, -32'sd1, 32'h5555_5555);
        issue_op(lfu_pkg::KIND_GET, -32'sd1, 32'sd0);
        issue_op(lfu_pkg::KIND_GET, 32'h7fff_ffff, 32'sd0);
    endtask

    task automatic test_victim_order();
        write_capacity(5'd3);
        issue_op(lfu_pkg::KIND_PUT, 32'h100, 32'h1111_0000);
        issue_op(lfu_pkg::KIND_PUT, 32'h200, 32'h2222_0000);
        issue_op(lfu_pkg::KIND_GET, 32'h100, 32'sd0);
        issue_op(lfu_pkg::KIND_PUT, 32'h300, 32'h3333_0000);
        issue_op(lfu_pkg::KIND_PUT, 32'h400, 32'h4444_0000);
        issue_op(lfu_pkg::KIND_GET, 32'h300, 32'sd0);
        issue_op(lfu_pkg::KIND_GET, 32'h100, 32'sd0);
    endtask

    task automatic test_zero_capacity();
        write_capacity(5'd0);
        issue_op(lfu_pkg::KIND_PUT, 32'h100, 32'hdead_beef);
        issue_op(lfu_pkg::KIND_PUT, 32'h999, 32'h0bad_f00d);
        issue_op(lfu_pkg::KIND_GET, 32'h100, 32'sd0);
        issue_op(lfu_pkg::KIND_GET, 32'h999, 32'sd0);
    endtask

    task automatic test_capacity_shrink();
        write_capacity(5'd16);
        for (int i = 0; i < 4; i++)
        begin
            issue_op(lfu_pkg::KIND_PUT, 32'h7000 + i, $urandom);
        end
        write_capacity(5'd1);
        issue_op(lfu_pkg::KIND_PUT, 32'h7100, 32'sd17);
        issue_op(lfu_pkg::KIND_PUT, 32'h7101, 32'sd18);
        issue_op(lfu_pkg::KIND_GET, 32'h7100, 32'sd0);
        write_capacity(5'd31);
    endtask

    // a line read many times outlives newer lines with fewer uses
    task automatic test_use_count_order();
        write_capacity(5'd2);
        issue_op(lfu_pkg::KIND_PUT, 32'h5a5a_0001, 32'h0f0f_0f0f);
        for (int i = 0; i < 20; i++)
        begin
            issue_op(lfu_pkg::KIND_GET, 32'h5a5a_0001, 32'sd0);
        end
        issue_op(lfu_pkg::KIND_PUT, 32'h5a5a_0002, 32'sd2);
        issue_op(lfu_pkg::KIND_GET, 32'h5a5a_0001, 32'sd0);
        issue_op(lfu_pkg::KIND_PUT, 32'h5a5a_0003, 32'sd3);
        issue_op(lfu_pkg::KIND_GET, 32'h5a5a_0001, 32'sd0);
        issue_op(lfu_pkg::KIND_GET, 32'h5a5a_0002, 32'sd0);
    endtask

    task automatic test_reply_backpressure();
        bit keep_req;
        keep_req = req_idle_on;
        write_capacity(5'd16);
        req_idle_on     = 1'b0;
        rsp_hold_cycles = 400;
        for (int i = 0; i < 12; i++)
        begin
            random_op();
        end
        settle();
        req_idle_on = keep_req;
    endtask

    task automatic test_random_traffic();
        logic [lfu_pkg::CAP_W-1:0] caps [8];
        caps = '{5'd16, 5'd3, 5'd1, 5'd0, 5'd31, 5'd7, 5'd2, 5'd16};
        for (int p = 0; p < 8; p++)
        begin
            write_capacity(caps[p]);
            req_idle_on = (p % 3) != 2;
            rsp_idle_on = (p % 4) != 3;
            for (int n = 0; n < 55; n++)
            begin
                random_op();
            end
        end
        req_idle_on = 1'b1;
        rsp_idle_on = 1'b1;
    endtask

    initial
    begin
        rst_n                  <= 1'b0;
        cfg_ch.valid           <= 1'b0;
        cfg_ch.capacity_in_use <= lfu_pkg::CAP_RESET;
        req_ch.valid           <= 1'b0;
        req_ch.kind            <= lfu_pkg::KIND_GET;
        req_ch.lookup_key      <= '0;
        req_ch.store_value     <= '0;
        offering        = 1'b0;
        req_idle_on     = 1'b1;
        rsp_idle_on     = 1'b1;
        rsp_hold_cycles = 0;
        clear_shadow();
        key_pool[0] = 32'h8000_0000;
        key_pool[1] = 32'h7fff_ffff;
        key_pool[2] = 32'sd0;
        key_pool[3] = -32'sd1;
        for (int i = 4; i < POOL_SIZE; i++)
        begin
            key_pool[i] = $urandom;
        end
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_lookup_and_store();
        test_victim_order();
        test_zero_capacity();
        test_capacity_shrink();
        test_use_count_order();
        test_reply_backpressure();
        test_random_traffic();

        settle();
        repeat (2 * SCAN_CYCLES) @(posedge clk);
        $display("covered %0d gets and %0d puts, %0d hits, %0d capacity writes",
                 gets_sent, puts_sent, hits_seen, capacity_writes);
        $display("including repeat hits, zero and shrunken capacity, a long reply stall");
        if (error_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
